[hdl/sign_magnitude_integer_alu_assert.svh]
// Assertion macros for the sign-magnitude integer unit.
// Both macros sample on clk and are held off while arst_n is low.
`ifndef SIGN_MAGNITUDE_INTEGER_ALU_ASSERT_SVH
`define SIGN_MAGNITUDE_INTEGER_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SMIA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sign_magnitude_integer_alu: check failed");
`define SMIA_ASSERT_NEXT(lbl, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("sign_magnitude_integer_alu: sequence check failed");
`else
`define SMIA_ASSERT(lbl, prop)
`define SMIA_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

[hdl/smia_pkg.sv]
package smia_pkg;

	localparam int MAG_WIDTH = 32;
	localparam int CNT_W     = $clog2(MAG_WIDTH + 1);

	typedef enum logic [4:0] {
		OP_ADD     = 5'd0,
		OP_SUB     = 5'd1,
		OP_MUL     = 5'd2,
		OP_DIV     = 5'd3,
		OP_MOD     = 5'd4,
		OP_NEG     = 5'd5,
		OP_EQ      = 5'd6,
		OP_NE      = 5'd7,
		OP_GT      = 5'd8,
		OP_LT      = 5'd9,
		OP_LE      = 5'd10,
		OP_GE      = 5'd11,
		OP_GCD     = 5'd12,
		OP_LCM     = 5'd13,
		OP_COPRIME = 5'd14,
		OP_PRIME   = 5'd15,
		OP_ODD     = 5'd16,
		OP_EVEN    = 5'd17
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_GCD,
		ST_PRIME,
		ST_EVAL,
		ST_DONE
	} state_t;

	// Step of an lcm: gcd loop, division of a by the gcd, final product.
	typedef enum logic [1:0] {
		PH_GCD,
		PH_QUO,
		PH_MUL
	} phase_t;

	typedef struct packed {
		logic                 neg;
		logic [MAG_WIDTH-1:0] mag;
		logic                 test;
		logic                 ovf;
		logic                 dz;
	} res_t;

endpackage

[hdl/smia_in_if.sv]
interface smia_in_if import smia_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [4:0]           opcode;
	logic                 a_negative;
	logic [MAG_WIDTH-1:0] a_mag;
	logic                 b_negative;
	logic [MAG_WIDTH-1:0] b_mag;

	modport source (output valid, output opcode, output a_negative, output a_mag,
		output b_negative, output b_mag, input ready);
	modport sink (input valid, input opcode, input a_negative, input a_mag,
		input b_negative, input b_mag, output ready);
endinterface

[hdl/smia_out_if.sv]
interface smia_out_if import smia_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 result_negative;
	logic [MAG_WIDTH-1:0] result_mag;
	logic                 test_true;
	logic                 overflow;
	logic                 divide_by_zero;

	modport source (output valid, output result_negative, output result_mag,
		output test_true, output overflow, output divide_by_zero, input ready);
	modport sink (input valid, input result_negative, input result_mag,
		input test_true, input overflow, input divide_by_zero, output ready);
endinterface

[hdl/sign_magnitude_integer_alu.sv]
// Sign-magnitude integer unit. Each item carries an opcode and two operands, each a sign
// bit and a MAG_WIDTH-bit magnitude, and yields exactly one result item. The unit takes
// one item at a time: req.ready is high only while the sequencer is idle, and a finished
// result sits in an output register, so a new item can be taken while rsp waits. Add,
// subtract, negate, compares, odd and even are computed in the accepting cycle.
// Multiply, divide and remainder run a shared shift-add / restoring-divide unit one bit
// per cycle. Gcd and coprime run Euclid on that unit, one division per remainder step;
// lcm adds one more division and one multiply.
// The primality test divides by 3, 5, 7, ... while the square of the divisor does not
// exceed the operand, so a large prime costs up to about 2^(MAG_WIDTH/2 - 1) divisions;
// composites and small values finish much sooner.
`include "sign_magnitude_integer_alu_assert.svh"

module sign_magnitude_integer_alu import smia_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	smia_in_if.sink    req,
	smia_out_if.source rsp
);

	localparam int W = MAG_WIDTH;

	state_t             state_q, state_d;
	phase_t             ph_q;
	logic [4:0]         op_q;
	logic               an_q, bn_q;
	logic [W-1:0]       a_q, b_q;
	logic [W-1:0]       x_q, y_q;
	logic [W:0]         acc_q;
	logic [W-1:0]       lo_q;
	logic [W+1:0]       sq_q;
	logic [CNT_W-1:0]   cnt_q;
	res_t               stg_q, out_q;
	logic               ovalid_q;

	logic               take;
	logic               last_bit;
	logic               out_free;
	res_t               quick;
	res_t               eval_res;
	logic [W:0]         mul_sum;
	logic [W:0]         div_sh;
	logic               div_ge;
	logic [W:0]         div_rem;

	// A zero magnitude is always reported as positive.
	function automatic res_t zero_pos(input res_t r);
		res_t o;
		o = r;
		if (r.mag == '0) begin
			o.neg = 1'b0;
		end
		return o;
	endfunction

	assign take     = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign last_bit = (cnt_q == CNT_W'(W - 1));
	assign out_free = !ovalid_q || rsp.ready;

	// Shared unit: shift-add multiply step and restoring divide step.
	assign mul_sum = {1'b0, acc_q[W-1:0]} + (lo_q[0] ? {1'b0, x_q} : '0);
	assign div_sh  = {acc_q[W-1:0], lo_q[W-1]};
	assign div_ge  = div_sh >= {1'b0, y_q};
	assign div_rem = div_ge ? div_sh - {1'b0, y_q} : div_sh;

	// Operations that finish in the accepting cycle, plus the early exits of the others.
	always_comb begin
		logic         bneg;
		logic         an0, bn0;
		logic         eq, gt, lt;
		logic [W:0]   s;
		quick = '0;
		bneg  = req.b_negative ^ (req.opcode == OP_SUB);
		an0   = req.a_negative && (req.a_mag != '0);
		bn0   = req.b_negative && (req.b_mag != '0);
		eq    = (an0 == bn0) && (req.a_mag == req.b_mag);
		gt    = 1'b0;
		s     = {1'b0, req.a_mag} + {1'b0, req.b_mag};
		if (an0 != bn0) begin
			gt = !an0;
		end else if (req.a_mag > req.b_mag) begin
			gt = !an0;
		end else if (req.a_mag < req.b_mag) begin
			gt = an0;
		end
		lt = !eq && !gt;
		case (req.opcode)
			OP_ADD, OP_SUB: begin
				if (req.a_negative == bneg) begin
					quick.mag = s[W-1:0];
					quick.ovf = s[W];
					quick.neg = req.a_negative;
				end else if (req.a_mag > req.b_mag) begin
					quick.mag = req.a_mag - req.b_mag;
					quick.neg = req.a_negative;
				end else if (req.a_mag < req.b_mag) begin
					quick.mag = req.b_mag - req.a_mag;
					quick.neg = bneg;
				end
			end
			OP_NEG: begin
				quick.mag = req.a_mag;
				quick.neg = !req.a_negative;
			end
			OP_DIV, OP_MOD: quick.dz = 1'b1;
			OP_EQ:    quick.test = eq;
			OP_NE:    quick.test = !eq;
			OP_GT:    quick.test = gt;
			OP_LT:    quick.test = lt;
			OP_LE:    quick.test = !gt;
			OP_GE:    quick.test = !lt;
			OP_PRIME: quick.test = (req.a_mag == W'(2)) || (req.a_mag == W'(3));
			OP_ODD:   quick.test = req.a_mag[0];
			OP_EVEN:  quick.test = !req.a_mag[0];
			default:  quick = '0;
		endcase
		quick = zero_pos(quick);
	end

	// Results formed from the shared unit once a pass through it ends.
	always_comb begin
		eval_res = '0;
		case (op_q)
			OP_MUL: begin
				eval_res.mag = lo_q;
				eval_res.ovf = |acc_q[W-1:0];
				eval_res.neg = an_q ^ bn_q;
			end
			OP_DIV: begin
				eval_res.mag = lo_q;
				eval_res.neg = an_q ^ bn_q;
			end
			OP_MOD: begin
				eval_res.mag = acc_q[W-1:0];
				eval_res.neg = an_q;
			end
			OP_LCM: begin
				eval_res.mag = lo_q;
				eval_res.ovf = |acc_q[W-1:0];
			end
			default: eval_res = '0;
		endcase
		eval_res = zero_pos(eval_res);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (req.opcode)
						OP_MUL: state_d = ST_MUL;
						OP_DIV, OP_MOD: state_d = (req.b_mag == '0) ? ST_DONE : ST_DIV;
						OP_GCD, OP_COPRIME: state_d = ST_GCD;
						OP_LCM: begin
							state_d = (req.a_mag == '0 || req.b_mag == '0) ? ST_DONE : ST_GCD;
						end
						OP_PRIME: begin
							state_d = (req.a_mag < W'(4) || !req.a_mag[0]) ? ST_DONE : ST_PRIME;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_MUL, ST_DIV: begin
				if (last_bit) begin
					state_d = ST_EVAL;
				end
			end
			ST_GCD: begin
				if (y_q != '0 || (op_q == OP_LCM)) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PRIME: state_d = (sq_q > {2'b00, a_q}) ? ST_DONE : ST_DIV;
			ST_EVAL: begin
				case (op_q)
					OP_GCD, OP_COPRIME: state_d = ST_GCD;
					OP_LCM: begin
						if (ph_q == PH_GCD) begin
							state_d = ST_GCD;
						end else if (ph_q == PH_QUO) begin
							state_d = ST_MUL;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_PRIME: state_d = (acc_q[W-1:0] == '0) ? ST_DONE : ST_PRIME;
					default: state_d = ST_DONE;
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers of the shared unit and the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					op_q  <= req.opcode;
					an_q  <= req.a_negative;
					bn_q  <= req.b_negative;
					a_q   <= req.a_mag;
					b_q   <= req.b_mag;
					x_q   <= req.a_mag;
					// The primality test starts with divisor 3.
					y_q   <= (req.opcode == OP_PRIME) ? W'(3) : req.b_mag;
					acc_q <= '0;
					cnt_q <= '0;
					ph_q  <= PH_GCD;
					stg_q <= quick;
					sq_q  <= (W+2)'(9);
					if (req.opcode == OP_MUL) begin
						lo_q <= req.b_mag;
					end else begin
						lo_q <= req.a_mag;
					end
				end
			end
			ST_MUL: begin
				acc_q <= {1'b0, mul_sum[W:1]};
				lo_q  <= {mul_sum[0], lo_q[W-1:1]};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_DIV: begin
				acc_q <= div_rem;
				lo_q  <= {lo_q[W-2:0], div_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_GCD: begin
				acc_q <= '0;
				cnt_q <= '0;
				if (y_q != '0) begin
					lo_q <= x_q;
				end else if (op_q == OP_LCM) begin
					// Divide a by the gcd now held in x_q.
					lo_q <= a_q;
					y_q  <= x_q;
					ph_q <= PH_QUO;
				end else begin
					stg_q <= '{neg: 1'b0,
						mag: (op_q == OP_GCD) ? x_q : '0,
						test: (op_q == OP_COPRIME) && (x_q == W'(1)),
						ovf: 1'b0,
						dz: 1'b0};
				end
			end
			ST_PRIME: begin
				acc_q <= '0;
				cnt_q <= '0;
				lo_q  <= a_q;
				stg_q <= '{neg: 1'b0, mag: '0, test: (sq_q > {2'b00, a_q}),
					ovf: 1'b0, dz: 1'b0};
			end
			ST_EVAL: begin
				acc_q <= '0;
				cnt_q <= '0;
				stg_q <= eval_res;
				case (op_q)
					OP_GCD, OP_COPRIME: begin
						x_q <= y_q;
						y_q <= acc_q[W-1:0];
					end
					OP_LCM: begin
						if (ph_q == PH_GCD) begin
							x_q <= y_q;
							y_q <= acc_q[W-1:0];
						end else if (ph_q == PH_QUO) begin
							x_q  <= b_q;
							ph_q <= PH_MUL;
						end
					end
					OP_PRIME: begin
						// (d + 2)^2 = d^2 + 4d + 4
						y_q  <= y_q + W'(2);
						sq_q <= sq_q + {y_q, 2'b00} + (W+2)'(4);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Output register: loaded from the staged result once the last one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= stg_q;
		end
	end

	assign rsp.valid           = ovalid_q;
	assign rsp.result_negative = out_q.neg;
	assign rsp.result_mag      = out_q.mag;
	assign rsp.test_true       = out_q.test;
	assign rsp.overflow        = out_q.ovf;
	assign rsp.divide_by_zero  = out_q.dz;

	// A zero result is never negative.
	`SMIA_ASSERT(a_zero_pos, !(rsp.valid && rsp.result_mag == '0 && rsp.result_negative))
	// Divide by zero and overflow come from disjoint operations.
	`SMIA_ASSERT(a_flags_excl, !(rsp.valid && rsp.divide_by_zero && rsp.overflow))
	// A predicate result carries no magnitude.
	`SMIA_ASSERT(a_test_nomag, !(rsp.valid && rsp.test_true && rsp.result_mag != '0))
	// Once an item is taken the unit is not ready in the next cycle.
	`SMIA_ASSERT_NEXT(a_busy_after_take, req.valid && req.ready, !req.ready)

endmodule
